### rtl/core/ffha_pkg.sv
package ffha_pkg;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_REALLOC = 2'd2,
        MODE_ZALLOC  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_SPACE     = 3'd1,
        ST_BAD_SIZE     = 3'd2,
        ST_IGNORED      = 3'd3,
        ST_ALREADY_FREE = 3'd4,
        ST_BAD_ADDRESS  = 3'd5
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] request_bytes;
        logic [31:0] count;
        logic [12:0] address;
    } in_item_t;

    typedef struct packed {
        logic [12:0] result_address;
        logic [11:0] copy_bytes;
        logic [11:0] zero_bytes;
        status_t     status;
    } out_item_t;

    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_CLEAR,
        UOP_LOAD,
        UOP_MULT,
        UOP_BYTES_REQ,
        UOP_BYTES_PROD,
        UOP_NEED_SETUP,
        UOP_NEED_LOC,
        UOP_LOC,
        UOP_RD_P,
        UOP_RD_N,
        UOP_FIT_NEXT,
        UOP_FIT_TAKE,
        UOP_CARVE_TAIL,
        UOP_CARVE_HEAD,
        UOP_OLD,
        UOP_RELEASE,
        UOP_RE_INPLACE,
        UOP_RE_NEXT,
        UOP_RE_ABSORB,
        UOP_FIT_START,
        UOP_MG_FREE,
        UOP_MG_ABSORB,
        UOP_MG_CLOSE,
        UOP_FIN,
        UOP_OUT
    } uop_t;

    typedef struct packed {
        uop_t    uop;
        status_t code;
        logic    set_copy;
    } cmd_t;

    typedef struct packed {
        logic  clr_done;
        logic  heap_ready;
        mode_t mode;
        logic  addr_zero;
        logic  req_zero;
        logic  cnt_zero;
        logic  prod_high;
        logic  round_bad;
        logic  loc_bad;
        logic  live;
        logic  blk_free;
        logic  fits;
        logic  in_place;
        logic  absorb_ok;
        logic  out_busy;
    } stat_t;

endpackage

### rtl/core/ffha_ctrl.sv
module ffha_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ffha_pkg::stat_t stat,
    output ffha_pkg::cmd_t  cmd
);
    import ffha_pkg::*;

    typedef enum logic [21:0] {
        S_CLEAR    = 22'h000001,
        S_IDLE     = 22'h000002,
        S_DECODE   = 22'h000004,
        S_ZCHK     = 22'h000008,
        S_ROUND    = 22'h000010,
        S_FIT_RD   = 22'h000020,
        S_FIT_CHK  = 22'h000040,
        S_TAIL     = 22'h000080,
        S_HEAD     = 22'h000100,
        S_REL      = 22'h000200,
        S_MG_RD    = 22'h000400,
        S_MG_P     = 22'h000800,
        S_MG_NRD   = 22'h001000,
        S_MG_N     = 22'h002000,
        S_FREE_CHK = 22'h004000,
        S_FREE_LOC = 22'h008000,
        S_RE_RND   = 22'h010000,
        S_RE_LOC   = 22'h020000,
        S_RE_DEC   = 22'h040000,
        S_RE_NRD   = 22'h080000,
        S_RE_N     = 22'h100000,
        S_DONE     = 22'h200000
    } state_t;

    state_t state_reg, state_next;
    logic   move_reg, move_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            move_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            move_reg  <= move_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        move_next    = move_reg;
        req_ready    = 1'b0;
        cmd.uop      = UOP_NONE;
        cmd.code     = ST_OK;
        cmd.set_copy = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.uop = UOP_CLEAR;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.uop    = UOP_LOAD;
                    move_next  = 1'b0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.mode)
                    MODE_ALLOC:
                    begin
                        cmd.uop    = UOP_BYTES_REQ;
                        state_next = S_ROUND;
                    end
                    MODE_FREE:
                    begin
                        state_next = S_FREE_CHK;
                    end
                    MODE_REALLOC:
                    begin
                        if (stat.addr_zero)
                        begin
                            cmd.uop    = UOP_BYTES_REQ;
                            state_next = S_ROUND;
                        end
                        else if (stat.req_zero)
                        begin
                            state_next = S_FREE_CHK;
                        end
                        else
                        begin
                            cmd.uop    = UOP_BYTES_REQ;
                            state_next = S_RE_RND;
                        end
                    end
                    MODE_ZALLOC:
                    begin
                        cmd.uop    = UOP_MULT;
                        state_next = S_ZCHK;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ZCHK:
            begin
                if (stat.cnt_zero || stat.req_zero || stat.prod_high)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_BAD_SIZE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.uop    = UOP_BYTES_PROD;
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (stat.round_bad)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_BAD_SIZE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.uop    = UOP_NEED_SETUP;
                    state_next = S_FIT_RD;
                end
            end
            S_FIT_RD:
            begin
                cmd.uop    = UOP_RD_P;
                state_next = S_FIT_CHK;
            end
            S_FIT_CHK:
            begin
                if (!stat.live)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_NO_SPACE;
                    state_next = S_DONE;
                end
                else if (stat.blk_free && stat.fits)
                begin
                    cmd.uop    = UOP_FIT_TAKE;
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd.uop    = UOP_FIT_NEXT;
                    state_next = S_FIT_RD;
                end
            end
            S_TAIL:
            begin
                cmd.uop    = UOP_CARVE_TAIL;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.uop    = UOP_CARVE_HEAD;
                state_next = move_reg ? S_REL : S_DONE;
            end
            S_REL:
            begin
                cmd.uop      = UOP_RELEASE;
                cmd.set_copy = move_reg;
                state_next   = S_MG_RD;
            end
            S_MG_RD:
            begin
                cmd.uop    = UOP_RD_P;
                state_next = S_MG_P;
            end
            S_MG_P:
            begin
                if (!stat.live)
                begin
                    state_next = S_DONE;
                end
                else if (stat.blk_free)
                begin
                    cmd.uop    = UOP_MG_FREE;
                    state_next = S_MG_NRD;
                end
                else
                begin
                    cmd.uop    = UOP_FIT_NEXT;
                    state_next = S_MG_RD;
                end
            end
            S_MG_NRD:
            begin
                cmd.uop    = UOP_RD_N;
                state_next = S_MG_N;
            end
            S_MG_N:
            begin
                if (stat.live && stat.blk_free)
                begin
                    cmd.uop    = UOP_MG_ABSORB;
                    state_next = S_MG_NRD;
                end
                else
                begin
                    cmd.uop    = UOP_MG_CLOSE;
                    state_next = S_MG_RD;
                end
            end
            S_FREE_CHK:
            begin
                if (stat.addr_zero || !stat.heap_ready)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_IGNORED;
                    state_next = S_DONE;
                end
                else if (stat.loc_bad)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_BAD_ADDRESS;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.uop    = UOP_LOC;
                    state_next = S_FREE_LOC;
                end
            end
            S_FREE_LOC:
            begin
                if (!stat.live)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_BAD_ADDRESS;
                    state_next = S_DONE;
                end
                else if (stat.blk_free)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_ALREADY_FREE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.uop    = UOP_OLD;
                    state_next = S_REL;
                end
            end
            S_RE_RND:
            begin
                if (stat.round_bad)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_BAD_SIZE;
                    state_next = S_DONE;
                end
                else if (stat.loc_bad)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_BAD_ADDRESS;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.uop    = UOP_NEED_LOC;
                    state_next = S_RE_LOC;
                end
            end
            S_RE_LOC:
            begin
                if (!stat.live)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_BAD_ADDRESS;
                    state_next = S_DONE;
                end
                else if (stat.blk_free)
                begin
                    cmd.uop    = UOP_FIN;
                    cmd.code   = ST_ALREADY_FREE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.uop    = UOP_OLD;
                    state_next = S_RE_DEC;
                end
            end
            S_RE_DEC:
            begin
                if (stat.in_place)
                begin
                    cmd.uop    = UOP_RE_INPLACE;
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd.uop    = UOP_RE_NEXT;
                    state_next = S_RE_NRD;
                end
            end
            S_RE_NRD:
            begin
                cmd.uop    = UOP_RD_N;
                state_next = S_RE_N;
            end
            S_RE_N:
            begin
                if (stat.live && stat.blk_free && stat.absorb_ok)
                begin
                    cmd.uop    = UOP_RE_ABSORB;
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd.uop    = UOP_FIT_START;
                    move_next  = 1'b1;
                    state_next = S_FIT_RD;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.uop    = UOP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/ffha_datapath.sv
module ffha_datapath #(
    parameter int POOL_BYTES   = 4096,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffha_pkg::in_item_t  req,
    input  ffha_pkg::cmd_t      cmd,
    output ffha_pkg::stat_t     stat,
    output ffha_pkg::out_item_t rsp,
    output logic                rsp_valid,
    input  logic                rsp_ready
);
    import ffha_pkg::*;

    localparam int UNIT_COUNT = POOL_BYTES / ALIGN_BYTES;
    localparam int HDR_SPAN   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int HDR_UNITS  = HDR_SPAN / ALIGN_BYTES;
    localparam int AL         = $clog2(ALIGN_BYTES);
    localparam int IW         = $clog2(UNIT_COUNT);
    localparam int NW         = IW + 1;
    localparam logic [NW-1:0] HDR_U  = NW'(HDR_UNITS);
    localparam logic [NW-1:0] INIT_U = NW'(UNIT_COUNT - HDR_UNITS);

    typedef struct packed {
        logic          hdr;
        logic          free;
        logic [NW-1:0] size;
    } entry_t;

    entry_t mem [UNIT_COUNT];

    mode_t       mode_reg;
    logic [31:0] req_reg, cnt_reg, bytes_reg;
    logic [12:0] addr_reg, res_reg;
    logic [63:0] prod_reg;
    logic [NW-1:0] need_reg, p_reg, n_reg, psize_reg, tgt_reg, old_reg;
    logic [11:0] copy_reg;
    status_t     status_reg;
    logic        ready_reg, rinr_reg, rsp_valid_reg;
    logic [IW-1:0] clr_reg;
    entry_t      rdata_reg;
    out_item_t   rsp_reg;

    logic [32:0]   cu;
    logic          round_bad;
    logic [NW-1:0] need_val;
    logic [12:0]   d13;
    logic [31:0]   idx_w;
    logic          loc_bad;
    logic [NW-1:0] rsize;
    logic [NW+1:0] split_need;
    logic [NW:0]   r_full;
    logic          split_ok;
    logic [NW:0]   absorb_sum;
    logic [NW-1:0] mg_size;

    logic          wr_en;
    logic [31:0]   wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [31:0]   rd_addr;

    assign cu        = ({1'b0, bytes_reg} + 33'(ALIGN_BYTES - 1)) >> AL;
    assign round_bad = (bytes_reg == 32'd0) || (cu >= (33'd1 << (32 - AL)));
    assign need_val  = (cu > 33'({NW{1'b1}})) ? {NW{1'b1}} : NW'(cu);
    assign d13       = addr_reg - 13'(HDR_SPAN);
    assign idx_w     = 32'(d13) >> AL;
    assign loc_bad   = (addr_reg < 13'(HDR_SPAN)) || (d13[AL-1:0] != '0);
    assign rsize     = rdata_reg.size;
    assign split_need = (NW+2)'(need_reg) + (NW+2)'(HDR_UNITS) + (NW+2)'(1);
    assign r_full    = (NW+1)'(p_reg) + (NW+1)'(need_reg) + (NW+1)'(HDR_UNITS);
    assign split_ok  = ((NW+2)'(psize_reg) >= split_need) &&
                       (32'(r_full) < 32'(UNIT_COUNT));
    assign absorb_sum = (NW+1)'(old_reg) + (NW+1)'(HDR_UNITS) + (NW+1)'(rsize);
    assign mg_size   = psize_reg + HDR_U + rsize;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = 32'd0;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = 32'd0;
        case (cmd.uop)
            UOP_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = 32'(clr_reg);
            end
            UOP_NEED_SETUP:
            begin
                wr_en   = !ready_reg;
                wr_data = '{hdr: 1'b1, free: 1'b1, size: INIT_U};
            end
            UOP_CARVE_TAIL:
            begin
                wr_en   = split_ok;
                wr_addr = 32'(r_full);
                wr_data = '{hdr: 1'b1, free: 1'b1, size: psize_reg - need_reg - HDR_U};
            end
            UOP_CARVE_HEAD:
            begin
                wr_en   = 1'b1;
                wr_addr = 32'(p_reg);
                wr_data = '{hdr: 1'b1, free: 1'b0, size: psize_reg};
            end
            UOP_RELEASE:
            begin
                wr_en   = 1'b1;
                wr_addr = 32'(tgt_reg);
                wr_data = '{hdr: 1'b1, free: 1'b1, size: old_reg};
            end
            UOP_RE_ABSORB, UOP_MG_ABSORB:
            begin
                wr_en   = 1'b1;
                wr_addr = 32'(n_reg);
            end
            UOP_MG_CLOSE:
            begin
                wr_en   = 1'b1;
                wr_addr = 32'(p_reg);
                wr_data = '{hdr: 1'b1, free: 1'b1, size: psize_reg};
            end
            UOP_NEED_LOC, UOP_LOC:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_w;
            end
            UOP_RD_P:
            begin
                rd_en   = 1'b1;
                rd_addr = 32'(p_reg);
            end
            UOP_RD_N:
            begin
                rd_en   = 1'b1;
                rd_addr = 32'(n_reg);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[IW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en && (rd_addr < 32'(UNIT_COUNT)))
        begin
            rdata_reg <= mem[rd_addr[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg     <= 1'b0;
            clr_reg       <= '0;
            rinr_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.uop == UOP_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.uop == UOP_NEED_SETUP)
            begin
                ready_reg <= 1'b1;
            end
            if (rd_en)
            begin
                rinr_reg <= rd_addr < 32'(UNIT_COUNT);
            end
            if (cmd.uop == UOP_OUT)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.uop)
            UOP_LOAD:
            begin
                mode_reg   <= req.mode;
                req_reg    <= req.request_bytes;
                cnt_reg    <= req.count;
                addr_reg   <= req.address;
                status_reg <= ST_OK;
                copy_reg   <= '0;
                res_reg    <= '0;
            end
            UOP_MULT:       prod_reg  <= 64'(req_reg) * 64'(cnt_reg);
            UOP_BYTES_REQ:  bytes_reg <= req_reg;
            UOP_BYTES_PROD: bytes_reg <= prod_reg[31:0];
            UOP_NEED_SETUP:
            begin
                need_reg <= need_val;
                p_reg    <= '0;
            end
            UOP_NEED_LOC:
            begin
                need_reg <= need_val;
                tgt_reg  <= NW'(idx_w);
            end
            UOP_LOC:        tgt_reg   <= NW'(idx_w);
            UOP_FIT_NEXT:   p_reg     <= p_reg + HDR_U + rsize;
            UOP_FIT_TAKE:   psize_reg <= rsize;
            UOP_CARVE_TAIL:
            begin
                if (split_ok)
                begin
                    psize_reg <= need_reg;
                end
            end
            UOP_CARVE_HEAD:
                res_reg <= 13'((32'(p_reg) << AL) + 32'(HDR_SPAN));
            UOP_OLD:        old_reg   <= rsize;
            UOP_RELEASE:
            begin
                p_reg <= '0;
                if (cmd.set_copy)
                begin
                    copy_reg <= 12'(32'(old_reg) << AL);
                end
            end
            UOP_RE_INPLACE:
            begin
                psize_reg <= old_reg;
                p_reg     <= tgt_reg;
            end
            UOP_RE_NEXT:    n_reg     <= tgt_reg + HDR_U + old_reg;
            UOP_RE_ABSORB:
            begin
                psize_reg <= NW'(absorb_sum);
                p_reg     <= tgt_reg;
            end
            UOP_FIT_START:  p_reg     <= '0;
            UOP_MG_FREE:
            begin
                psize_reg <= rsize;
                n_reg     <= p_reg + HDR_U + rsize;
            end
            UOP_MG_ABSORB:
            begin
                psize_reg <= mg_size;
                n_reg     <= p_reg + HDR_U + mg_size;
            end
            UOP_MG_CLOSE:   p_reg      <= n_reg;
            UOP_FIN:        status_reg <= cmd.code;
            UOP_OUT:
            begin
                rsp_reg.result_address <= (status_reg == ST_OK) ? res_reg : '0;
                rsp_reg.copy_bytes     <= copy_reg;
                rsp_reg.zero_bytes     <= ((status_reg == ST_OK) && (mode_reg == MODE_ZALLOC))
                                          ? prod_reg[11:0] : '0;
                rsp_reg.status         <= status_reg;
            end
            default:
            begin
                status_reg <= status_reg;
            end
        endcase
    end

    assign stat.clr_done   = (clr_reg == IW'(UNIT_COUNT - 1));
    assign stat.heap_ready = ready_reg;
    assign stat.mode       = mode_reg;
    assign stat.addr_zero  = (addr_reg == 13'd0);
    assign stat.req_zero   = (req_reg == 32'd0);
    assign stat.cnt_zero   = (cnt_reg == 32'd0);
    assign stat.prod_high  = (prod_reg[63:32] != 32'd0);
    assign stat.round_bad  = round_bad;
    assign stat.loc_bad    = loc_bad;
    assign stat.live       = rinr_reg && rdata_reg.hdr;
    assign stat.blk_free   = rdata_reg.free;
    assign stat.fits       = rsize >= need_reg;
    assign stat.in_place   = need_reg <= old_reg;
    assign stat.absorb_ok  = absorb_sum >= (NW+1)'(need_reg);
    assign stat.out_busy   = rsp_valid_reg && !rsp_ready;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("memory read and write hit the same entry");

    a_write_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr < 32'(UNIT_COUNT)))
        else $error("memory write outside the pool");

    a_ready_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |=> ready_reg)
        else $error("heap ready flag dropped");

    a_out_from_uop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.uop == UOP_OUT))
        else $error("result item raised without an output command");

endmodule

### rtl/core/first_fit_heap_allocator.sv
// Allocate walks the block list from the start for the first free block that fits; zero-allocate
// first multiplies size by count, and a bad size is rejected before any block walk.
// Free releases the block, then walks the whole list and merges each run of adjacent free blocks.
// Reallocate stays in place or grows into a free next block; a move adds search and merge walk.
// One item is in flight; req_ready rises with rsp_valid, even while the result waits to be taken.
// After reset a clearing pass over all POOL_BYTES/ALIGN_BYTES entries runs before the first item.
module first_fit_heap_allocator #(
    parameter int POOL_BYTES   = 4096,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ffha_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ffha_pkg::out_item_t rsp
);
    import ffha_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffha_datapath #(
        .POOL_BYTES   (POOL_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule
